@@ rtl/chi_pkg.sv @@
`timescale 1ns / 1ps

package chi_pkg;

    // operation codes
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DELETE  = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // result codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_BUCKET_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    // fixed field widths
    localparam int HASH_W  = 32;
    localparam int ID_W    = 32;
    localparam int CNT_W   = 9;
    localparam int TOMB_W  = 16;
    localparam int SLOT_OUT_W = 8;

    typedef struct packed {
        logic [1:0]        kind;
        logic [HASH_W-1:0] hash_code;
        logic [ID_W-1:0]   tag;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [CNT_W-1:0]      live_count;
        logic [TOMB_W-1:0]     tombstone_count;
    } out_word_t;

endpackage

@@ rtl/chi_mod_unit.sv @@
`timescale 1ns / 1ps

module chi_mod_unit
    import chi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);

    localparam int ITER_W = $clog2(HASH_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    trial;

    // one restoring step per cycle, most significant bit first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[HASH_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(HASH_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            else
                rem_next = CNT_W'(trial);
            dvd_next  = {dvd_reg[HASH_W-2:0], 1'b0};
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/chained_hash_index.sv @@
`timescale 1ns / 1ps

// Hash index of HT_SLOTS buckets of BUCKET_WAYS ways, one operation per input word
// (insert, delete, compact) and one result word per operation. After reset the
// bucket fill table is cleared, bucket by bucket, before the first word is taken.
// The slot is found by a bit-serial remainder unit, one hash bit at a time. Insert
// then reads the bucket fill and writes the new way; delete reads and checks the
// filled ways one by one; compact walks every bucket, reading its fill and then each
// filled way, since the way memory gives one registered read per cycle. A result may
// wait in the output register while the next word is accepted.
module chained_hash_index
    import chi_pkg::*;
#(
    parameter int HT_SLOTS    = 256,
    parameter int BUCKET_WAYS = 8,
    parameter int KEY_BITS    = 32,
    parameter int ID_BITS     = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(HT_SLOTS);
    localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
    localparam int ADDR_W = $clog2(HT_SLOTS * BUCKET_WAYS);
    localparam int WAY_W  = 1 + KEY_BITS + ID_BITS;
    localparam logic [TOMB_W-1:0] TOMB_MAX = '1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_MOD   = 10'b0000000100,
        S_FRD   = 10'b0000001000,
        S_FEV   = 10'b0000010000,
        S_DRD   = 10'b0000100000,
        S_DEV   = 10'b0001000000,
        S_CRD   = 10'b0010000000,
        S_CEV   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic                live;
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } way_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   src_reg, src_next;
    logic [FILL_W-1:0]   dst_reg, dst_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [1:0]          kind_reg, kind_next;
    logic [HASH_W-1:0]   key_reg, key_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [1:0]          status_reg, status_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [TOMB_W-1:0]   tomb_reg, tomb_next;
    logic [CNT_W-1:0]    slots_reg;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg, out_word_next;

    // memories
    logic [FILL_W-1:0]   fill_mem [HT_SLOTS];
    way_t                way_mem [HT_SLOTS * BUCKET_WAYS];
    logic [FILL_W-1:0]   fill_q;
    way_t                way_q;

    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;
    logic                way_we;
    logic [ADDR_W-1:0]   way_waddr;
    logic [ADDR_W-1:0]   way_raddr;
    way_t                way_wdata;
    logic [ADDR_W-1:0]   base;

    logic                mod_start;
    logic                mod_done;
    logic [CNT_W-1:0]    mod_rem;
    logic [CNT_W-1:0]    eff_slots;
    logic                accept;
    logic                out_free;
    logic [FILL_W-1:0]   dst_inc;

    // slot count clamped to 1..HT_SLOTS
    always_comb
    begin
        eff_slots = slots_reg;
        if (eff_slots == '0)
            eff_slots = CNT_W'(1);
        if (HT_SLOTS < (1 << CNT_W) && eff_slots > CNT_W'(HT_SLOTS))
            eff_slots = CNT_W'(HT_SLOTS);
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign mod_start = accept && (in_word.kind == KIND_INSERT || in_word.kind == KIND_DELETE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign base      = ADDR_W'(slot_reg) * ADDR_W'(BUCKET_WAYS);
    assign way_raddr = base + ADDR_W'(src_reg);
    assign dst_inc   = dst_reg + FILL_W'(way_q.live);

    chi_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_word.hash_code),
        .divisor   (eff_slots),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        fill_next      = fill_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        id_next        = id_reg;
        status_next    = status_reg;
        live_next      = live_reg;
        tomb_next      = tomb_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        fill_we        = 1'b0;
        fill_wdata     = '0;
        way_we         = 1'b0;
        way_waddr      = base + ADDR_W'(dst_reg);
        way_wdata      = way_q;

        unique case (state_reg)
            S_CLEAR:
            begin
                fill_we = 1'b1;
                slot_next = slot_reg + SLOT_W'(1);
                if (slot_reg == SLOT_W'(HT_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = in_word.kind;
                    key_next    = in_word.hash_code;
                    id_next     = in_word.tag;
                    status_next = ST_OK;
                    slot_next   = '0;
                    case (in_word.kind) inside
                        KIND_INSERT, KIND_DELETE: state_next = S_MOD;
                        KIND_COMPACT:             state_next = S_FRD;
                        default:                  state_next = S_FIN;
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    slot_next  = SLOT_W'(mod_rem);
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FEV;
            end
            S_FEV:
            begin
                fill_next = fill_q;
                src_next  = '0;
                dst_next  = '0;
                if (kind_reg == KIND_INSERT)
                begin
                    state_next = S_FIN;
                    if (live_reg >= eff_slots)
                        status_next = ST_TABLE_FULL;
                    else if (fill_q >= FILL_W'(BUCKET_WAYS))
                        status_next = ST_BUCKET_FULL;
                    else
                    begin
                        way_we     = 1'b1;
                        way_waddr  = base + ADDR_W'(fill_q);
                        way_wdata  = '{live: 1'b1, key: KEY_BITS'(key_reg),
                                       id: ID_BITS'(id_reg)};
                        fill_we    = 1'b1;
                        fill_wdata = fill_q + FILL_W'(1);
                        live_next  = live_reg + CNT_W'(1);
                    end
                end
                else if (kind_reg == KIND_DELETE)
                begin
                    if (fill_q == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FIN;
                    end
                    else
                        state_next = S_DRD;
                end
                else
                begin
                    // compact: skip empty buckets
                    if (fill_q != '0)
                        state_next = S_CRD;
                    else if (slot_reg == SLOT_W'(HT_SLOTS - 1))
                    begin
                        tomb_next  = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = S_FRD;
                    end
                end
            end
            S_DRD:
            begin
                state_next = S_DEV;
            end
            S_DEV:
            begin
                // first in-use way with a matching id becomes a tombstone
                if (way_q.live && way_q.id == ID_BITS'(id_reg))
                begin
                    way_we         = 1'b1;
                    way_waddr      = way_raddr;
                    way_wdata.live = 1'b0;
                    if (live_reg != '0)
                        live_next = live_reg - CNT_W'(1);
                    if (tomb_reg != TOMB_MAX)
                        tomb_next = tomb_reg + TOMB_W'(1);
                    state_next = S_FIN;
                end
                else if (src_reg + FILL_W'(1) == fill_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    src_next   = src_reg + FILL_W'(1);
                    state_next = S_DRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CEV;
            end
            S_CEV:
            begin
                // move in-use ways down over tombstones
                if (way_q.live)
                    way_we = 1'b1;
                dst_next = dst_inc;
                src_next = src_reg + FILL_W'(1);
                if (src_reg + FILL_W'(1) == fill_reg)
                begin
                    fill_we    = 1'b1;
                    fill_wdata = dst_inc;
                    if (slot_reg == SLOT_W'(HT_SLOTS - 1))
                    begin
                        tomb_next  = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = S_FRD;
                    end
                end
                else
                    state_next = S_CRD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next.status = status_reg;
                    out_word_next.slot_index =
                        (kind_reg == KIND_INSERT || kind_reg == KIND_DELETE)
                        ? SLOT_OUT_W'(slot_reg) : '0;
                    out_word_next.live_count      = live_reg;
                    out_word_next.tombstone_count = tomb_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            slot_reg      <= '0;
            live_reg      <= '0;
            tomb_reg      <= '0;
            slots_reg     <= CNT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            live_reg      <= live_next;
            tomb_reg      <= tomb_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                slots_reg <= cfg_data;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        fill_reg     <= fill_next;
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        id_reg       <= id_next;
        status_reg   <= status_next;
        out_word_reg <= out_word_next;
    end

    // bucket fill memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[slot_reg] <= fill_wdata;
        fill_q <= fill_mem[slot_reg];
    end

    // way memory
    always_ff @(posedge clk)
    begin
        if (way_we)
            way_mem[way_waddr] <= way_wdata;
        way_q <= way_mem[way_raddr];
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ rtl/chi_checker.sv @@
`timescale 1ns / 1ps

module chi_checker
    import chi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word,
    input logic      cfg_ready
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // an accepted word leaves the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting a word");

    // a new result only follows work in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without an operation in progress");

    // configuration always writable
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind chained_hash_index chi_checker u_chi_checker (.*);
